@@ rtl/ipe_pkg.sv @@
// Shared types and constants for the integer partition enumerator.
`default_nettype none
package ipe_pkg;

	localparam int PART_W      = 6;   // width of one part / target
	localparam int MAX_RESULTS = 32;  // most parts one partition may emit

	// input selector codes (travel on s_tuser)
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_NEXT  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CK,
		ST_FILL,
		ST_EMIT_RD,
		ST_EMIT_WR,
		ST_EXH
	} ipe_state_t;

endpackage
`default_nettype wire

@@ rtl/integer_partition_enumerator_unit.sv @@
// Top level of the integer partition enumerator: sequencer, part store and output register.
`default_nettype none
// Integer partition enumerator. Walks the partitions of a target integer into
// non-increasing parts in reverse lexicographic order, from the single part
// equal to the target down to all ones. A start beat (s_tuser = 0) loads the
// target from s_tdata and emits the one-part partition; a next beat
// (s_tuser = 1) computes the successor and emits it. Every partition leaves
// as one output beat per part, the final part flagged by m_tlast. Once the
// all-ones partition has been passed (or nothing is loaded, or the target is
// zero) a single exhausted beat is sent: part 0, m_tlast = 1, m_tuser = 1,
// and it repeats on every next beat until a new start. Targets above
// min(MAX_VALUE, 32) saturate to that limit.
// One beat is worked on at a time; s_tready is high only in idle. The part
// store is a single-port-read memory with registered read data. A start
// writes the saturated target as the only part and emits it. A next beat
// scans back over the trailing ones, lowers the first larger part, writes
// the refill parts after it and then emits every part; if the scan reaches
// the front of an all-ones partition an exhausted beat is sent instead.
// Stalls on m_tready hold the sequencer until the output register is free.
// No clearing pass is needed after reset.
module integer_partition_enumerator_unit
	import ipe_pkg::*;
#(
	parameter int MAX_VALUE = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [5:0] target_value, [7:6] zero
	input  logic [0:0]  s_tuser,   // [0] kind
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [5:0] part, [7:6] zero
	output logic        m_tlast,   // last_part
	output logic [0:0]  m_tuser    // [0] exhausted
);

	localparam int IW  = $clog2(MAX_VALUE);
	// largest target that still fits both the store and one result run
	localparam int LIM = (MAX_VALUE < MAX_RESULTS) ? MAX_VALUE : MAX_RESULTS;

	ipe_state_t state_q, state_nxt;

	// part store
	logic [PART_W-1:0] mem [MAX_VALUE];
	logic [PART_W-1:0] rd_data_q;
	logic [IW-1:0]     rd_addr;
	logic              wr_en;
	logic [IW-1:0]     wr_addr;
	logic [PART_W-1:0] wr_data;

	// sequencer registers
	logic [IW-1:0]     top_q;      // index of last part
	logic              finished_q; // nothing loaded or enumeration over
	logic [IW-1:0]     k_q;        // scan / refill pointer
	logic [PART_W-1:0] rest_q;     // remainder to redistribute
	logic [PART_W-1:0] val_q;      // lowered part value used for refill
	logic [IW-1:0]     e_q;        // emit pointer

	// output register
	logic              m_valid_q;
	logic [PART_W-1:0] part_q;
	logic              last_q;
	logic              exh_q;

	logic              in_acc;
	logic              out_free;
	logic              is_start;
	logic [PART_W-1:0] tgt;
	logic [PART_W-1:0] tgt_sat;
	logic [IW:0]       k_inc;
	logic              k_room;
	logic              rd_is_one;
	logic              refill;
	logic              out_load_part;
	logic              out_load_exh;

	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign is_start  = (s_tuser[0] == KIND_START);
	assign tgt       = s_tdata[PART_W-1:0];
	assign tgt_sat   = (tgt > PART_W'(LIM)) ? PART_W'(LIM) : tgt;
	assign k_inc     = {1'b0, k_q} + 1'b1;
	assign k_room    = k_inc < (IW+1)'(MAX_VALUE);
	assign rd_is_one = (rd_data_q == PART_W'(1));
	// the remainder exceeds the lowered part and the store has room for another part
	assign refill    = (rest_q > val_q) && k_room;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (is_start) begin
						state_nxt = (tgt == '0) ? ST_EXH : ST_EMIT_RD;
					end else begin
						state_nxt = finished_q ? ST_EXH : ST_SCAN_RD;
					end
				end
			end
			ST_SCAN_RD: state_nxt = ST_SCAN_CK;
			ST_SCAN_CK: begin
				if (rd_is_one) begin
					state_nxt = (k_q == '0) ? ST_EXH : ST_SCAN_RD;
				end else begin
					state_nxt = ST_FILL;
				end
			end
			ST_FILL: begin
				if (!refill) begin
					state_nxt = ST_EMIT_RD;
				end
			end
			ST_EMIT_RD: state_nxt = ST_EMIT_WR;
			ST_EMIT_WR: begin
				if (out_free) begin
					state_nxt = (e_q == top_q) ? ST_IDLE : ST_EMIT_RD;
				end
			end
			ST_EXH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready      = 1'b0;
		wr_en         = 1'b0;
		wr_addr       = k_q;
		wr_data       = rest_q;
		rd_addr       = k_q;
		out_load_part = 1'b0;
		out_load_exh  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && is_start && (tgt != '0)) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = tgt_sat;
				end
			end
			ST_SCAN_RD: rd_addr = k_q;
			ST_SCAN_CK: begin
				rd_addr = k_q;
				if (!rd_is_one) begin
					wr_en   = 1'b1;
					wr_addr = k_q;
					wr_data = rd_data_q - PART_W'(1);
				end
			end
			ST_FILL: begin
				wr_en   = k_room;
				wr_addr = k_inc[IW-1:0];
				wr_data = (rest_q > val_q) ? val_q : rest_q;
			end
			ST_EMIT_RD: rd_addr = e_q;
			ST_EMIT_WR: begin
				rd_addr       = e_q;
				out_load_part = out_free;
			end
			ST_EXH: out_load_exh = out_free;
			default: ;
		endcase
	end

	// part store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			top_q      <= '0;
			finished_q <= 1'b1;
			k_q        <= '0;
			rest_q     <= '0;
			val_q      <= '0;
			e_q        <= '0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						e_q <= '0;
						if (is_start) begin
							if (tgt == '0) begin
								finished_q <= 1'b1;
							end else begin
								top_q      <= '0;
								finished_q <= 1'b0;
							end
						end else begin
							k_q    <= top_q;
							rest_q <= '0;
						end
					end
				end
				ST_SCAN_CK: begin
					rest_q <= rest_q + PART_W'(1);
					if (rd_is_one) begin
						if (k_q == '0) begin
							finished_q <= 1'b1;  // all ones passed
						end else begin
							k_q <= k_q - 1'b1;
						end
					end else begin
						val_q <= rd_data_q - PART_W'(1);
					end
				end
				ST_FILL: begin
					if (refill) begin
						rest_q <= rest_q - val_q;
						k_q    <= k_inc[IW-1:0];
					end else begin
						top_q <= k_room ? k_inc[IW-1:0] : k_q;
					end
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						e_q <= e_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load_part || out_load_exh) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load_part) begin
			part_q <= rd_data_q;
			last_q <= (e_q == top_q);
			exh_q  <= 1'b0;
		end else if (out_load_exh) begin
			part_q <= '0;
			last_q <= 1'b1;
			exh_q  <= 1'b1;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = {(8-PART_W)'(0), part_q};
	assign m_tlast    = last_q;
	assign m_tuser[0] = exh_q;

	// an exhausted beat always closes its run
	a_exh_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tlast)
		else $error("exhausted beat without tlast");

	// a loaded partition never outgrows the limit
	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		!finished_q |-> ({1'b0, top_q} < (IW+1)'(LIM)))
		else $error("top index beyond limit");

	// refill works with a nonzero part and remainder
	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> ((val_q != '0) && (rest_q != '0)))
		else $error("refill with zero part or remainder");

	// emission never reads past the last part
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_WR) |-> (e_q <= top_q))
		else $error("emit pointer past last part");

endmodule
`default_nettype wire

@@ tb/integer_partition_enumerator_unit_tb.sv @@
// Self-checking testbench for integer_partition_enumerator_unit: stream stimulus and scoreboard.
module integer_partition_enumerator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ipe_pkg::*;

	localparam int MAX_VALUE      = 32;
	localparam int ITEM_GOAL      = 230;
	localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat on either side
	localparam int TAIL_CYCLES    = 200;   // drain time after the last expected beat

	// one expected output beat
	typedef struct {
		logic [PART_W-1:0] part;
		logic              last;
		logic              exh;
	} part_beat_t;

	// Tracks the current partition and queues the beats each request should produce.
	class partition_scoreboard;
		logic [PART_W-1:0] cur_parts [MAX_VALUE];
		int                last_idx;
		bit                enum_done;
		part_beat_t        pending_parts [$];
		int                errors;

		function new();
			foreach (cur_parts[i]) cur_parts[i] = '0;
			last_idx  = 0;
			enum_done = 1'b1;  // nothing loaded after reset
			errors    = 0;
		endfunction

		function void push_exhausted();
			part_beat_t b;
			b.part = '0;
			b.last = 1'b1;
			b.exh  = 1'b1;
			pending_parts.push_back(b);
		endfunction

		function void push_partition();
			part_beat_t b;
			for (int i = 0; i <= last_idx && i < MAX_VALUE && i < MAX_RESULTS; i++) begin
				b.part = cur_parts[i];
				b.last = (i == last_idx);
				b.exh  = 1'b0;
				pending_parts.push_back(b);
			end
		endfunction

		// accepted input beat: update the partition, queue its output beats
		function void note_request(logic kind, logic [PART_W-1:0] target);
			int k;
			int rest;
			int lim;
			lim = (MAX_VALUE < MAX_RESULTS) ? MAX_VALUE : MAX_RESULTS;
			if (kind == KIND_START) begin
				if (target == '0) begin
					enum_done = 1'b1;
					push_exhausted();
				end else begin
					cur_parts[0] = (target > lim) ? PART_W'(lim) : target;
					last_idx     = 0;
					enum_done    = 1'b0;
					push_partition();
				end
			end else if (enum_done) begin
				push_exhausted();
			end else begin
				// gather trailing ones into the remainder
				k    = last_idx;
				rest = 0;
				while (k >= 0 && cur_parts[k] == 1) begin
					rest++;
					k--;
				end
				if (k < 0) begin
					// all ones already: enumeration over, partition untouched
					enum_done = 1'b1;
					push_exhausted();
				end else begin
					cur_parts[k] = cur_parts[k] - 1'b1;
					rest++;
					// refill with copies of the lowered part, then the rest
					while (rest > cur_parts[k] && k + 1 < MAX_VALUE) begin
						cur_parts[k+1] = cur_parts[k];
						rest          -= cur_parts[k];
						k++;
					end
					if (k + 1 < MAX_VALUE) begin
						cur_parts[k+1] = PART_W'(rest);
						k++;
					end
					last_idx = k;
					push_partition();
				end
			end
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		// accepted output beat: compare with the oldest expectation
		task check_beat(logic [7:0] data, logic last, logic exh);
			part_beat_t want;
			if (pending_parts.size() == 0) begin
				report_mismatch($sformatf("unexpected beat part=%0d last=%0b exhausted=%0b",
					data, last, exh));
			end else begin
				want = pending_parts.pop_front();
				if (data !== {{(8-PART_W){1'b0}}, want.part})
					report_mismatch($sformatf("part: got %0d, want %0d", data, want.part));
				if (last !== want.last)
					report_mismatch($sformatf("last_part: got %0b, want %0b", last, want.last));
				if (exh !== want.exh)
					report_mismatch($sformatf("exhausted: got %0b, want %0b", exh, want.exh));
			end
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;   // [5:0] target_value, [7:6] zero
	logic [0:0]  s_tuser  = '0;   // [0] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [5:0] part, [7:6] zero
	logic        m_tlast;         // last_part
	logic [0:0]  m_tuser;         // [0] exhausted

	partition_scoreboard sb = new();

	bit calm          = 1'b0;  // both sides skip idling while set
	bit stall_request = 1'b0;  // asks the receiver for one long hold-off
	int items_sent    = 0;
	int quiet_cycles  = 0;

	integer_partition_enumerator_unit #(
		.MAX_VALUE(MAX_VALUE)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	// Offer one beat, with a random gap first, and hold it until accepted.
	task automatic send_item(input logic kind, input logic [PART_W-1:0] target);
		while (!calm && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(8-PART_W){1'b0}}, target};
		do @(posedge clk); while (!s_tready);
		sb.note_request(kind, target);
		items_sent++;
	endtask

	// Advance until the enumeration runs out (the exhausted beat included).
	task automatic walk_to_end();
		do send_item(KIND_NEXT, PART_W'($urandom)); while (!sb.enum_done);
	endtask

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= calm || ($urandom_range(99) >= 16);
		end
	end

	// Output monitor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(m_tdata, m_tlast, m_tuser[0]);
	end

	// Watchdog: too long without a beat on either side means a hang.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stimulus.
	initial begin
		int          r;
		int          n_next;
		logic [PART_W-1:0] t;
		bit          pressed;
		pressed = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: advance with nothing loaded, zero target
		send_item(KIND_NEXT, 6'd5);
		send_item(KIND_START, 6'd0);
		send_item(KIND_NEXT, 6'd0);
		// target one: already all ones, then repeated exhaustion
		send_item(KIND_START, 6'd1);
		send_item(KIND_NEXT, 6'd0);
		send_item(KIND_NEXT, 6'd63);
		// full walk of a small target
		send_item(KIND_START, 6'd4);
		walk_to_end();
		send_item(KIND_NEXT, 6'd0);
		// largest legal target, saturating targets (all bits set, one above the limit)
		send_item(KIND_START, 6'd32);
		send_item(KIND_NEXT, 6'd0);
		send_item(KIND_NEXT, 6'd0);
		send_item(KIND_START, 6'd63);
		send_item(KIND_NEXT, 6'd0);
		send_item(KIND_START, 6'd33);
		send_item(KIND_START, 6'd2);
		walk_to_end();

		// random: mostly start-then-advance sequences, some stray beats
		while (items_sent < ITEM_GOAL) begin
			calm = (items_sent >= 70 && items_sent < 120);
			if (!pressed && items_sent >= 160) begin
				stall_request = 1'b1;
				pressed       = 1'b1;
			end
			r = $urandom_range(99);
			if (r < 8) begin
				send_item(1'($urandom_range(1)), PART_W'($urandom));
			end else begin
				r = $urandom_range(99);
				if (r < 75)      t = PART_W'($urandom_range(8, 1));
				else if (r < 90) t = PART_W'($urandom_range(20, 9));
				else if (r < 96) t = PART_W'($urandom_range(63, 21));
				else             t = '0;
				send_item(KIND_START, t);
				if (t != 0 && t <= 8 && $urandom_range(1)) begin
					walk_to_end();
					n_next = $urandom_range(2);
				end else begin
					n_next = $urandom_range(6);
				end
				repeat (n_next) send_item(KIND_NEXT, PART_W'($urandom));
			end
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		while (sb.pending_parts.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_parts.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
